@@ rtl/wmfp_pkg.sv @@
// Shared types, constants and helpers for the management frame receive parser.
// Used by every module under rtl/.
package wmfp_pkg;

   localparam int MAX_FRAME_BYTES = 4096;
   localparam int SSID_LIMIT      = 32;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES) + 1;
   localparam int HDR_LEN         = 24;
   localparam int ELEM_START      = 36;
   localparam int ADDR3_START     = 16;
   localparam logic [15:0] AID_MASK = 16'h3FFF;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam logic [2:0] CLS_BEACON  = 3'd0;
   localparam logic [2:0] CLS_PROBE   = 3'd1;
   localparam logic [2:0] CLS_AUTH    = 3'd2;
   localparam logic [2:0] CLS_ASSOC   = 3'd3;
   localparam logic [2:0] CLS_MGMT    = 3'd4;
   localparam logic [2:0] CLS_DATA    = 3'd5;
   localparam logic [2:0] CLS_FOREIGN = 3'd6;
   localparam logic [2:0] CLS_SHORT   = 3'd7;

   localparam logic [7:0] EID_SSID = 8'd0;
   localparam logic [7:0] EID_DS   = 8'd3;
   localparam logic [7:0] EID_RSN  = 8'd48;

   localparam logic [1:0] PH_ID    = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_FIRST = 2'd2;
   localparam logic [1:0] PH_BODY  = 2'd3;

   localparam logic RK_SSID    = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   typedef struct packed {
      logic        has_ssid;
      logic [7:0]  ssid_byte;
      logic        ssid_restart;
      logic        has_sum;
      logic [2:0]  frame_class;
      logic [47:0] bssid;
      logic [7:0]  channel;
      logic        privacy;
      logic        auth_success;
      logic [15:0] status_value;
      logic [13:0] association_id;
      logic        link_up;
   } entry_type;

   function automatic logic [2:0] classify(input logic [7:0] b);
      logic [1:0] t;
      logic [3:0] s;
      logic [2:0] c;
      t = b[3:2];
      s = b[7:4];
      if (t == 2'd1 || t == 2'd3)  c = CLS_FOREIGN;
      else if (t == 2'd2)          c = CLS_DATA;
      else if (s == 4'd8)          c = CLS_BEACON;
      else if (s == 4'd5)          c = CLS_PROBE;
      else if (s == 4'd11)         c = CLS_AUTH;
      else if (s == 4'd1)          c = CLS_ASSOC;
      else                         c = CLS_MGMT;
      return c;
   endfunction

endpackage

@@ rtl/wifi_mgmt_frame_rx_parser_unit.sv @@
// 802.11 management frame receive parser: top level.
// Instantiates wmfp_front, wmfp_queue and wmfp_back; uses wmfp_pkg.
//
// Usage: frame bytes enter on the req_ stream, one item per byte, req_tlast
// on the final byte of a frame. Results leave on the rsp_ stream:
// rsp_tuser 0 is an SSID byte item, 1 is the frame summary item; rsp_tlast
// marks the last result caused by one input byte.
// Throughput: one byte per cycle while the result queue has a free entry. A
// byte that yields both an SSID item and the summary holds its entry until
// both leave; the four-entry result queue absorbs that and output stalls.
// A result is written into a registered queue entry when its byte is
// accepted (the front-end state is registered too) and reaches rsp_ from
// there once the queue has passed on any earlier results.
// Receiver stall: results wait in the queue; req_tready drops only when
// all four entries are held, and bytes that cause no result still need a
// free entry slot to be accepted.
// Reset: synchronous; clears the parse state, link flag and queue.
// No clearing pass; the block accepts bytes the cycle after reset.
module wifi_mgmt_frame_rx_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // frame_byte
   input  logic         req_tlast,   // frame_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ssid_byte, ssid_restart, frame_class, bssid, channel, privacy,
   // auth_success, status_value, association_id, link_up, zero pad
   output logic [103:0] rsp_tdata,
   output logic         rsp_tuser,   // result_kind
   output logic         rsp_tlast    // last_of_run
);

   logic                push;
   logic                pop;
   logic                q_not_full;
   logic                q_not_empty;
   wmfp_pkg::entry_type push_entry;
   wmfp_pkg::entry_type head;

   wmfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .q_ready    (q_not_full),
      .in_ready   (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   wmfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_full   (q_not_full),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   wmfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata),
      .out_kind   (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule

@@ rtl/wmfp_front.sv @@
// Front end: accepts frame bytes, tracks header fields and walks elements.
// Produces one queue entry per byte that causes results. Uses wmfp_pkg.
module wmfp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_end,
   input  logic                 q_ready,
   output logic                 in_ready,
   output logic                 push,
   output wmfp_pkg::entry_type  push_entry
);

   logic [wmfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  eid_ff, eid_in;
   logic [7:0]  left_ff, left_in;
   logic [47:0] addr_ff, addr_in;
   logic [7:0]  chan_ff, chan_in;
   logic        priv_ff, priv_in;
   logic [15:0] worda_ff, worda_in;
   logic [15:0] wordb_ff, wordb_in;
   logic        emit_ff, emit_in;
   logic        conn_ff, conn_in;
   logic        accept;
   logic        in_range;
   logic [7:0]  left_dec;
   logic [2:0]  cls;
   wmfp_pkg::entry_type e;

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;
   assign in_range = pos_ff < wmfp_pkg::POS_W'(wmfp_pkg::MAX_FRAME_BYTES);
   assign left_dec = left_ff - 8'd1;

   always_comb begin
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      phase_in = phase_ff;
      eid_in   = eid_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      chan_in  = chan_ff;
      priv_in  = priv_ff;
      worda_in = worda_ff;
      wordb_in = wordb_ff;
      emit_in  = emit_ff;
      conn_in  = conn_ff;
      e        = '0;
      cls      = '0;
      if (in_range) begin
         if (pos_ff == '0) kind_in = wmfp_pkg::classify(in_byte);
         if (kind_in != wmfp_pkg::CLS_FOREIGN) begin
            for (int k = 0; k < 6; k++) begin
               if (pos_ff == wmfp_pkg::POS_W'(wmfp_pkg::ADDR3_START + k))
                  addr_in[8*k +: 8] = in_byte;
            end
            if (pos_ff == wmfp_pkg::POS_W'(26)) worda_in = {8'd0, in_byte};
            if (pos_ff == wmfp_pkg::POS_W'(27)) worda_in = {in_byte, worda_ff[7:0]};
            if (pos_ff == wmfp_pkg::POS_W'(28)) wordb_in = {8'd0, in_byte};
            if (pos_ff == wmfp_pkg::POS_W'(29)) wordb_in = {in_byte, wordb_ff[7:0]};
            if (kind_in <= wmfp_pkg::CLS_PROBE &&
                pos_ff >= wmfp_pkg::POS_W'(wmfp_pkg::ELEM_START)) begin
               unique case (phase_ff)
                  wmfp_pkg::PH_ID: begin
                     eid_in   = in_byte;
                     phase_in = wmfp_pkg::PH_LEN;
                  end
                  wmfp_pkg::PH_LEN: begin
                     left_in = in_byte;
                     emit_in = (eid_ff == wmfp_pkg::EID_SSID) &&
                               ({1'b0, in_byte} < 9'(wmfp_pkg::SSID_LIMIT));
                     if (eid_ff == wmfp_pkg::EID_DS && in_byte != 8'd0) chan_in = 8'd0;
                     if (eid_ff == wmfp_pkg::EID_RSN) priv_in = 1'b1;
                     phase_in = (in_byte != 8'd0) ? wmfp_pkg::PH_FIRST : wmfp_pkg::PH_ID;
                  end
                  default: begin
                     if (emit_ff) begin
                        e.has_ssid     = 1'b1;
                        e.ssid_byte    = in_byte;
                        e.ssid_restart = (phase_ff == wmfp_pkg::PH_FIRST);
                     end
                     if (phase_ff == wmfp_pkg::PH_FIRST && eid_ff == wmfp_pkg::EID_DS)
                        chan_in = in_byte;
                     left_in  = left_dec;
                     phase_in = (left_dec != 8'd0) ? wmfp_pkg::PH_BODY : wmfp_pkg::PH_ID;
                  end
               endcase
            end
         end
         pos_in = pos_ff + 1'b1;
      end
      if (in_end) begin
         cls = kind_in;
         if (cls != wmfp_pkg::CLS_FOREIGN && pos_in < wmfp_pkg::POS_W'(wmfp_pkg::HDR_LEN))
            cls = wmfp_pkg::CLS_SHORT;
         if (cls == wmfp_pkg::CLS_ASSOC && worda_in == 16'd0) conn_in = 1'b1;
         e.has_sum     = 1'b1;
         e.frame_class = cls;
         if (cls <= wmfp_pkg::CLS_DATA) e.bssid = addr_in;
         if (cls <= wmfp_pkg::CLS_PROBE) begin
            e.channel = chan_in;
            e.privacy = priv_in;
         end
         if (cls == wmfp_pkg::CLS_AUTH) begin
            e.auth_success = (worda_in == 16'd2) && (wordb_in == 16'd0);
            e.status_value = wordb_in;
         end
         if (cls == wmfp_pkg::CLS_ASSOC) begin
            e.status_value   = worda_in;
            e.association_id = 14'(wordb_in & wmfp_pkg::AID_MASK);
         end
         e.link_up = conn_in;
         pos_in   = '0;
         kind_in  = '0;
         phase_in = wmfp_pkg::PH_ID;
         eid_in   = '0;
         left_in  = '0;
         addr_in  = '0;
         chan_in  = '0;
         priv_in  = 1'b0;
         worda_in = '0;
         wordb_in = '0;
         emit_in  = 1'b0;
      end
   end

   assign push       = accept && (e.has_ssid || e.has_sum);
   assign push_entry = e;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         kind_ff  <= '0;
         phase_ff <= wmfp_pkg::PH_ID;
         eid_ff   <= '0;
         left_ff  <= '0;
         addr_ff  <= '0;
         chan_ff  <= '0;
         priv_ff  <= 1'b0;
         worda_ff <= '0;
         wordb_ff <= '0;
         emit_ff  <= 1'b0;
         conn_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         phase_ff <= phase_in;
         eid_ff   <= eid_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         chan_ff  <= chan_in;
         priv_ff  <= priv_in;
         worda_ff <= worda_in;
         wordb_ff <= wordb_in;
         emit_ff  <= emit_in;
         conn_ff  <= conn_in;
      end
   end

endmodule

@@ rtl/wmfp_queue.sv @@
// Short FIFO of result entries between front end and output stage.
// Uses wmfp_pkg.
module wmfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wmfp_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 not_full,
   output logic                 not_empty,
   output wmfp_pkg::entry_type  head
);

   wmfp_pkg::entry_type slots_ff [wmfp_pkg::Q_DEPTH];
   logic [wmfp_pkg::Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [wmfp_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign not_full  = cnt_ff != wmfp_pkg::Q_CNT_W'(wmfp_pkg::Q_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = slots_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + wmfp_pkg::Q_CNT_W'(push) - wmfp_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_entry;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= wmfp_pkg::Q_CNT_W'(wmfp_pkg::Q_DEPTH))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ff == rd_ff + cnt_ff[wmfp_pkg::Q_PTR_W-1:0])
      else $error("queue pointers out of step with count");

endmodule

@@ rtl/wmfp_back.sv @@
// Output stage: turns the queue head into one or two result items.
// Uses wmfp_pkg.
module wmfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  wmfp_pkg::entry_type  head,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [103:0]         out_data,
   output logic                 out_kind,
   output logic                 out_last
);

   logic sent_ff, sent_in;
   logic ssid_turn;
   logic take;

   assign ssid_turn = head.has_ssid && !sent_ff;
   assign out_valid = head_valid;
   assign take      = head_valid && out_ready;
   assign out_last  = !(ssid_turn && head.has_sum);
   assign pop       = take && out_last;
   assign out_kind  = ssid_turn ? wmfp_pkg::RK_SSID : wmfp_pkg::RK_SUMMARY;

   always_comb begin
      out_data = '0;
      if (ssid_turn) begin
         out_data[7:0] = head.ssid_byte;
         out_data[8]   = head.ssid_restart;
      end else begin
         out_data[11:9]   = head.frame_class;
         out_data[59:12]  = head.bssid;
         out_data[67:60]  = head.channel;
         out_data[68]     = head.privacy;
         out_data[69]     = head.auth_success;
         out_data[85:70]  = head.status_value;
         out_data[99:86]  = head.association_id;
         out_data[100]    = head.link_up;
      end
   end

   always_comb begin
      sent_in = sent_ff;
      if (pop) sent_in = 1'b0;
      else if (take) sent_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) sent_ff <= 1'b0;
      else sent_ff <= sent_in;
   end

   a_sent_two: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> head_valid && head.has_ssid && head.has_sum)
      else $error("split flag set without a two-result entry");
   a_sent_then_pop: assert property (@(posedge clock) disable iff (reset)
      sent_ff && out_ready |-> pop)
      else $error("summary half not retired");
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_kind == wmfp_pkg::RK_SUMMARY |-> out_last)
      else $error("summary result not last of run");

endmodule

@@ sim/tb_wifi_mgmt_frame_rx_parser_unit.sv @@
// Testbench for wifi_mgmt_frame_rx_parser_unit: streams directed and random frames
// into the parser and checks every SSID and summary item against a local predictor.
// Depends on rtl/wmfp_pkg.sv and the parser RTL.
`timescale 1ns / 100ps

module tb_wifi_mgmt_frame_rx_parser_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BYTES   = 1200;
   localparam int CALM_TAIL      = 150;

   typedef struct {
      bit          kind;
      logic [7:0]  ssid_byte;
      bit          restart;
      logic [2:0]  frame_class;
      logic [47:0] bssid;
      logic [7:0]  channel;
      bit          privacy;
      bit          auth_ok;
      logic [15:0] status_value;
      logic [13:0] aid;
      bit          link_up;
      bit          last;
   } parse_result_type;

   typedef struct {
      logic [7:0] data;
      bit         tail;
      bit         typed;
      logic [2:0] frame_class;
      bit         link_up;
   } vector_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   // predictor state
   int          pos;
   logic [2:0]  kind_q;
   logic [1:0]  phase;
   logic [7:0]  elem_id;
   logic [7:0]  elem_left;
   logic [47:0] addr3;
   logic [7:0]  chan_q;
   bit          priv_q;
   logic [15:0] word_a;
   logic [15:0] word_b;
   bit          ssid_on;
   bit          linked;
   logic [47:0] ap_addr;

   parse_result_type pending_results[$];
   vector_type       vectors[$];
   int               errors = 0;
   int               frames_sent = 0;
   int               bytes_sent = 0;
   int               results_seen = 0;
   int               ssid_seen = 0;
   int               quiet_cycles = 0;
   bit               idle_on = 1'b1;

   always #10 clock = ~clock;

   wifi_mgmt_frame_rx_parser_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic logic [2:0] frame_class_of(input logic [7:0] b);
      logic [2:0] c;
      case (b[3:2])
         2'd1, 2'd3: c = wmfp_pkg::CLS_FOREIGN;
         2'd2:       c = wmfp_pkg::CLS_DATA;
         default: begin
            case (b[7:4])
               4'd8:    c = wmfp_pkg::CLS_BEACON;
               4'd5:    c = wmfp_pkg::CLS_PROBE;
               4'd11:   c = wmfp_pkg::CLS_AUTH;
               4'd1:    c = wmfp_pkg::CLS_ASSOC;
               default: c = wmfp_pkg::CLS_MGMT;
            endcase
         end
      endcase
      return c;
   endfunction

   task automatic clear_frame_state();
      pos = 0; kind_q = 0; phase = wmfp_pkg::PH_ID; elem_id = 0; elem_left = 0; addr3 = 0;
      chan_q = 0; priv_q = 0; word_a = 0; word_b = 0; ssid_on = 0;
   endtask

   function automatic parse_result_type blank_result();
      parse_result_type r;
      r = '{default: 0};
      return r;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input bit tail);
      parse_result_type r;
      int n0;
      bit first;
      n0 = pending_results.size();
      if (pos < wmfp_pkg::MAX_FRAME_BYTES) begin
         if (pos == 0) kind_q = frame_class_of(b);
         if (kind_q != wmfp_pkg::CLS_FOREIGN) begin
            if (pos >= 16 && pos <= 21) addr3[8*(pos-16) +: 8] = b;
            else if (pos == 26) word_a = {8'h00, b};
            else if (pos == 27) word_a[15:8] = b;
            else if (pos == 28) word_b = {8'h00, b};
            else if (pos == 29) word_b[15:8] = b;
            if (kind_q <= wmfp_pkg::CLS_PROBE && pos >= wmfp_pkg::ELEM_START) begin
               if (phase == wmfp_pkg::PH_ID) begin
                  elem_id = b;
                  phase = wmfp_pkg::PH_LEN;
               end else if (phase == wmfp_pkg::PH_LEN) begin
                  elem_left = b;
                  ssid_on = (elem_id == wmfp_pkg::EID_SSID) && (b < wmfp_pkg::SSID_LIMIT);
                  if (elem_id == wmfp_pkg::EID_DS && b >= 1) chan_q = 0;
                  if (elem_id == wmfp_pkg::EID_RSN) priv_q = 1;
                  phase = (b != 0) ? wmfp_pkg::PH_FIRST : wmfp_pkg::PH_ID;
               end else begin
                  first = (phase == wmfp_pkg::PH_FIRST);
                  if (ssid_on) begin
                     r = blank_result();
                     r.kind = wmfp_pkg::RK_SSID;
                     r.ssid_byte = b;
                     r.restart = first;
                     pending_results.push_back(r);
                  end
                  if (first && elem_id == wmfp_pkg::EID_DS) chan_q = b;
                  elem_left = elem_left - 8'd1;
                  phase = (elem_left != 0) ? wmfp_pkg::PH_BODY : wmfp_pkg::PH_ID;
               end
            end
         end
         pos++;
      end
      if (tail) begin
         r = blank_result();
         r.kind = wmfp_pkg::RK_SUMMARY;
         r.frame_class = kind_q;
         if (kind_q != wmfp_pkg::CLS_FOREIGN && pos < wmfp_pkg::HDR_LEN)
            r.frame_class = wmfp_pkg::CLS_SHORT;
         if (r.frame_class == wmfp_pkg::CLS_ASSOC && word_a == 0) begin
            linked = 1;
            ap_addr = addr3;
         end
         if (r.frame_class <= wmfp_pkg::CLS_DATA) r.bssid = addr3;
         if (r.frame_class <= wmfp_pkg::CLS_PROBE) begin
            r.channel = chan_q;
            r.privacy = priv_q;
         end
         if (r.frame_class == wmfp_pkg::CLS_AUTH) begin
            r.auth_ok = (word_a == 16'd2 && word_b == 16'd0);
            r.status_value = word_b;
         end
         if (r.frame_class == wmfp_pkg::CLS_ASSOC) begin
            r.status_value = word_a;
            r.aid = word_b[13:0];
         end
         r.link_up = linked;
         pending_results.push_back(r);
         clear_frame_state();
      end
      if (pending_results.size() > n0) pending_results[$].last = 1;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit tail);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= tail;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, tail);
      bytes_sent++;
      if (tail) frames_sent++;
   endtask

   task automatic send_frame(input logic [7:0] fr[$]);
      foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
   endtask

   task automatic add_element(ref logic [7:0] fr[$], input logic [7:0] id, input int len);
      fr.push_back(id);
      fr.push_back(len[7:0]);
      repeat (len) fr.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic build_frame(output logic [7:0] fr[$]);
      int sel, len, cut;
      logic [7:0] b0;
      fr = {};
      sel = $urandom_range(0, 9);
      b0 = 8'($urandom_range(0, 255));
      case (sel)
         0, 1, 2, 3: begin
            b0[7:2] = {(sel < 2) ? 4'd8 : 4'd5, 2'd0};
            fr.push_back(b0);
            repeat (wmfp_pkg::ELEM_START - 1) fr.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 4))
                  0, 1: add_element(fr, wmfp_pkg::EID_SSID,
                           ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                                       : $urandom_range(0, 12));
                  2: add_element(fr, wmfp_pkg::EID_DS, $urandom_range(0, 2));
                  3: add_element(fr, wmfp_pkg::EID_RSN, $urandom_range(0, 6));
                  default: add_element(fr, 8'($urandom_range(0, 255)),
                                       $urandom_range(0, 8));
               endcase
            end
         end
         4, 5: begin
            b0[7:2] = {(sel == 4) ? 4'd11 : 4'd1, 2'd0};
            fr.push_back(b0);
            repeat (25) fr.push_back(8'($urandom_range(0, 255)));
            if (sel == 4) begin
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd2 : 8'($urandom_range(0, 255)));
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
            end else begin
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
               fr.push_back(($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
               fr.push_back(8'($urandom_range(0, 255)));
               fr.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 6)) fr.push_back(8'($urandom_range(0, 255)));
         end
         6: begin
            if (b0[3:2] == 2'd1 || b0[3:2] == 2'd3) b0[3] = 1'b0;
            fr.push_back(b0);
            repeat ($urandom_range(23, 40)) fr.push_back(8'($urandom_range(0, 255)));
         end
         7: begin
            b0[2] = 1'b1;
            fr.push_back(b0);
            repeat ($urandom_range(0, 30)) fr.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            b0[2] = 1'b0;
            fr.push_back(b0);
            repeat ($urandom_range(0, wmfp_pkg::HDR_LEN - 2))
               fr.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      // broken frames: cut anywhere
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, fr.size());
         while (fr.size() > cut) void'(fr.pop_back());
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (e.kind == wmfp_pkg::RK_SSID) ssid_seen++;
            check_field("result_kind", e.kind, rsp_tuser);
            check_field("ssid_byte", e.ssid_byte, rsp_tdata[7:0]);
            check_field("ssid_restart", e.restart, rsp_tdata[8]);
            check_field("frame_class", e.frame_class, rsp_tdata[11:9]);
            check_field("bssid", e.bssid, rsp_tdata[59:12]);
            check_field("channel", e.channel, rsp_tdata[67:60]);
            check_field("privacy", e.privacy, rsp_tdata[68]);
            check_field("auth_success", e.auth_ok, rsp_tdata[69]);
            check_field("status_value", e.status_value, rsp_tdata[85:70]);
            check_field("association_id", e.aid, rsp_tdata[99:86]);
            check_field("link_up", e.link_up, rsp_tdata[100]);
            check_field("pad", 64'd0, rsp_tdata[103:101]);
            check_field("last_of_run", e.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("tb_wifi_mgmt_frame_rx_parser_unit failed");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic add_vector(input logic [7:0] b, input bit tail, input bit typed,
                             input logic [2:0] cls, input bit link);
      vector_type v;
      v.data = b; v.tail = tail; v.typed = typed; v.frame_class = cls; v.link_up = link;
      vectors.push_back(v);
   endtask

   initial begin
      logic [7:0] fr[$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      linked = 0;
      ap_addr = 0;
      clear_frame_state();

      // one-byte frames, then a 24-byte association response with the status missing
      add_vector(8'h80, 1, 1, wmfp_pkg::CLS_SHORT, 0);
      add_vector(8'h04, 1, 1, wmfp_pkg::CLS_FOREIGN, 0);
      add_vector(8'h08, 1, 1, wmfp_pkg::CLS_SHORT, 0);
      add_vector(8'hFF, 1, 1, wmfp_pkg::CLS_FOREIGN, 0);
      add_vector(8'h00, 1, 1, wmfp_pkg::CLS_SHORT, 0);
      add_vector(8'h10, 0, 0, wmfp_pkg::CLS_ASSOC, 0);
      for (int i = 1; i < 24; i++)
         add_vector((i % 2) ? 8'hFF : 8'h00, i == 23, i == 23, wmfp_pkg::CLS_ASSOC, 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i]) begin
         send_byte(vectors[i].data, vectors[i].tail);
         if (vectors[i].typed && (pending_results[$].frame_class !== vectors[i].frame_class
               || pending_results[$].link_up !== vectors[i].link_up)) begin
            $error("directed row %0d: expected class %0d link %0d", i,
                   vectors[i].frame_class, vectors[i].link_up);
            errors++;
         end
      end

      while (bytes_sent < RANDOM_BYTES) begin
         if (bytes_sent > RANDOM_BYTES - CALM_TAIL) idle_on = 1'b0;
         if (frames_sent % 10 == 0 && pending_results.size() != 0) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         build_frame(fr);
         send_frame(fr);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d frames, %0d bytes sent; %0d result items checked, %0d of them SSID bytes",
               frames_sent, bytes_sent, results_seen, ssid_seen);
      if (errors == 0) begin
         $display("tb_wifi_mgmt_frame_rx_parser_unit passed");
      end else begin
         $display("tb_wifi_mgmt_frame_rx_parser_unit failed");
      end
      $finish;
   end

endmodule
